// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the table RTL of the triplet accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside of reset.
`define STA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// A condition that, once seen, forces a consequence on the next edge.
`define STA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/sta_pkg.sv =====
`default_nettype none

package sta_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int FIFO_DEPTH       = 2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    localparam logic [1:0] STATUS_ACCUM   = 2'd0;
    localparam logic [1:0] STATUS_INSERT  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        command;
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic        entry_valid;
        logic [15:0] out_row;
        logic [15:0] out_col;
        logic [31:0] out_value;
        logic [5:0]  position;
        logic [6:0]  entry_total;
        logic [15:0] top_row;
        logic [15:0] top_col;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sparse_triplet_accumulate_sort_top.sv =====
`default_nettype none

// Sparse-matrix triplet accumulator. Both channels look like queues.
// Input beats are written with push while full is low; each carries a command
// (add or emit), a row, a column and a value. Result beats are read with pop
// while empty is low; the oldest result sits on the result ports until popped.
// An add yields one status beat: accumulated, inserted or dropped when the
// table already holds CAPACITY entries. An emit yields one beat per stored
// entry in ascending row, then column order, with last on the final one; an
// empty table yields a single beat with entry_valid low.
// The table is kept sorted as entries are inserted, so an emit simply walks it.
// An add's status beat goes from the input queue pop through compare and apply
// into the result queue and then to the result ports; the apply waits while
// the result queue is full. An emit reads one stored entry at a time through
// the single table read port, waiting likewise while the result queue is full.
// A two-beat input queue decouples the writer, and a two-beat result queue
// lets the sequencer stall when the reader stops popping without losing data.
// Reset clears the queues, the entry count and the largest row and column.
module sparse_triplet_accumulate_sort_top #(
    parameter int CAPACITY = sta_pkg::DEFAULT_CAPACITY
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [15:0] row,
    input  wire logic [15:0] col,
    input  wire logic [31:0] value,
    input  wire logic        pop,
    output logic             empty,
    output logic             kind,
    output logic [1:0]       status,
    output logic             entry_valid,
    output logic [15:0]      out_row,
    output logic [15:0]      out_col,
    output logic [31:0]      out_value,
    output logic [5:0]       position,
    output logic [6:0]       entry_total,
    output logic [15:0]      top_row,
    output logic [15:0]      top_col,
    output logic             last
);

    sta_pkg::cmd_t    cmd_in;
    sta_pkg::cmd_t    cmd_q;
    logic             cmd_empty;
    logic             cmd_pop;
    sta_pkg::result_t res;
    sta_pkg::result_t res_q;
    logic             res_push;
    logic             res_full;

    assign cmd_in.command = command;
    assign cmd_in.row     = row;
    assign cmd_in.col     = col;
    assign cmd_in.value   = value;

    // Front: input queue of command beats.
    sta_fifo #(
        .WIDTH ($bits(sta_pkg::cmd_t))
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_q),
        .empty   (cmd_empty)
    );

    // Back: sorted table and sequencer.
    sta_table #(
        .CAPACITY (CAPACITY)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_q),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue toward the reader.
    sta_fifo #(
        .WIDTH ($bits(sta_pkg::result_t))
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign kind        = res_q.kind;
    assign status      = res_q.status;
    assign entry_valid = res_q.entry_valid;
    assign out_row     = res_q.out_row;
    assign out_col     = res_q.out_col;
    assign out_value   = res_q.out_value;
    assign position    = res_q.position;
    assign entry_total = res_q.entry_total;
    assign top_row     = res_q.top_row;
    assign top_col     = res_q.top_col;
    assign last        = res_q.last;

endmodule

`default_nettype wire

// ===== rtl/core/sta_fifo.sv =====
`default_nettype none

// Two-entry register queue.
module sta_fifo #(
    parameter int WIDTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [sta_pkg::FIFO_DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == 2'(sta_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sta_table.sv =====
`default_nettype none

// Entry table kept in sorted key order, with its sequencer.
module sta_table #(
    parameter int CAPACITY = sta_pkg::DEFAULT_CAPACITY
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sta_pkg::cmd_t   cmd,
    input  wire logic            cmd_empty,
    output logic                 cmd_pop,
    output sta_pkg::result_t     res,
    output logic                 res_push,
    input  wire logic            res_full
);

`include "assert_macros.svh"

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [31:0]         key_reg [CAPACITY];
    logic [31:0]         val_reg [CAPACITY];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [15:0]         top_row_reg;
    logic [15:0]         top_row_next;
    logic [15:0]         top_col_reg;
    logic [15:0]         top_col_next;
    sta_pkg::state_t     state_reg;
    sta_pkg::state_t     state_next;
    sta_pkg::cmd_t       cur_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] gt_reg;
    logic [CNT_W-1:0]    walk_reg;
    logic [CNT_W-1:0]    walk_next;

    logic [CAPACITY-1:0] match_c;
    logic [CAPACITY-1:0] gt_c;
    logic [31:0]         cur_key;
    logic [31:0]         hit_val;
    logic [31:0]         sum;
    logic                hit;
    logic                tbl_full;
    logic                ins;
    logic                in_apply;
    logic                in_emit;
    logic                apply_go;
    logic                emit_last;
    logic [IDX_W-1:0]    walk_idx;

    assign cur_key  = {cur_reg.row, cur_reg.col};
    assign hit      = |match_reg;
    assign tbl_full = (count_reg == CNT_W'(CAPACITY));
    assign ins      = !hit && !tbl_full;
    assign in_apply = (state_reg == sta_pkg::ST_APPLY);
    assign in_emit  = (state_reg == sta_pkg::ST_EMIT);
    assign apply_go = in_apply && !res_full;
    assign sum      = hit_val + cur_reg.value;
    assign walk_idx = walk_reg[IDX_W-1:0];
    assign emit_last = (count_reg == '0) || (walk_reg + CNT_W'(1) == count_reg);

    always_comb
    begin
        hit_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_c[i] = (CNT_W'(i) < count_reg) && (key_reg[i] == cur_key);
            gt_c[i]    = (CNT_W'(i) < count_reg) && (key_reg[i] > cur_key);
            hit_val    = hit_val | (val_reg[i] & {32{match_reg[i]}});
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        count_next   = count_reg;
        top_row_next = top_row_reg;
        top_col_next = top_col_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res          = '0;
        unique case (state_reg)
            sta_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    walk_next = '0;
                    state_next = (cmd.command == sta_pkg::CMD_ADD) ? sta_pkg::ST_CMP
                                                                   : sta_pkg::ST_EMIT;
                end
            end
            sta_pkg::ST_CMP:
            begin
                state_next = sta_pkg::ST_APPLY;
            end
            sta_pkg::ST_APPLY:
            begin
                if (ins)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (cur_reg.row > top_row_reg)
                    begin
                        top_row_next = cur_reg.row;
                    end
                    if (cur_reg.col > top_col_reg)
                    begin
                        top_col_next = cur_reg.col;
                    end
                end
                res.kind        = sta_pkg::KIND_ADD;
                res.status      = hit ? sta_pkg::STATUS_ACCUM
                                      : (ins ? sta_pkg::STATUS_INSERT : sta_pkg::STATUS_DROPPED);
                res.entry_total = 7'(count_next);
                res.top_row     = top_row_next;
                res.top_col     = top_col_next;
                res.last        = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = sta_pkg::ST_IDLE;
                end
                else
                begin
                    count_next   = count_reg;
                    top_row_next = top_row_reg;
                    top_col_next = top_col_reg;
                end
            end
            sta_pkg::ST_EMIT:
            begin
                res.kind        = sta_pkg::KIND_EMIT;
                res.status      = sta_pkg::STATUS_ACCUM;
                res.entry_total = 7'(count_reg);
                res.top_row     = top_row_reg;
                res.top_col     = top_col_reg;
                res.last        = emit_last;
                if (count_reg != '0)
                begin
                    res.entry_valid = 1'b1;
                    res.out_row     = key_reg[walk_idx][31:16];
                    res.out_col     = key_reg[walk_idx][15:0];
                    res.out_value   = val_reg[walk_idx];
                    res.position    = 6'(walk_reg);
                end
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (emit_last)
                    begin
                        state_next = sta_pkg::ST_IDLE;
                    end
                    else
                    begin
                        walk_next = walk_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = sta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sta_pkg::ST_IDLE;
            count_reg   <= '0;
            top_row_reg <= '0;
            top_col_reg <= '0;
            walk_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            top_row_reg <= top_row_next;
            top_col_reg <= top_col_next;
            walk_reg    <= walk_next;
        end
    end

    // Each slot either accumulates, takes its lower neighbor when a smaller
    // key is inserted below it, or takes the new entry at the insert point.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == sta_pkg::ST_CMP)
        begin
            match_reg <= match_c;
            gt_reg    <= gt_c;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (apply_go)
            begin
                if (hit && match_reg[i])
                begin
                    val_reg[i] <= sum;
                end
                else if (ins)
                begin
                    if ((i > 0) && gt_reg[(i > 0) ? i - 1 : 0])
                    begin
                        key_reg[i] <= key_reg[(i > 0) ? i - 1 : 0];
                        val_reg[i] <= val_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (gt_reg[i] || (CNT_W'(i) == count_reg))
                    begin
                        key_reg[i] <= cur_key;
                        val_reg[i] <= cur_reg.value;
                    end
                end
            end
        end
    end

    `STA_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `STA_ASSERT_ALWAYS(a_match_unique, !in_apply || $onehot0(match_reg))
    `STA_ASSERT_NEXT(a_insert_grows, apply_go && ins, count_reg == $past(count_reg) + CNT_W'(1))
    `STA_ASSERT_ALWAYS(a_walk_bound, !in_emit || (count_reg == '0) || (walk_reg < count_reg))

endmodule

`default_nettype wire
